// File: rtl/core/output_queue_admission_dt_ecn_macros.svh
// assertion macros shared by the output queue admission rtl
`ifndef OUTPUT_QUEUE_ADMISSION_DT_ECN_MACROS_SVH
`define OUTPUT_QUEUE_ADMISSION_DT_ECN_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define OQAD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define OQAD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/oqad_pkg.sv
// types, codes and constants of the output queue admission block
`timescale 1ns / 1ps
package oqad_pkg;

	// port count default
	localparam int NUM_PORTS_DEF = 16;

	// field widths
	localparam int QB_W    = 24;
	localparam int OCC_W   = 28;
	localparam int DROP_W  = 32;
	localparam int LEN_W   = 16;
	localparam int SHARE_W = 24;
	localparam int THR_W   = 32;

	// register reset values
	localparam int BUFFER_BYTES_RST  = 1048576;
	localparam int ACTIVE_PORTS_RST  = 16;
	localparam int PP_BUFFER_RST     = 131072;
	localparam int ECN_THR_KIB_RST   = 64;

	localparam logic [OCC_W-1:0] OCC_MAX = {OCC_W{1'b1}};
	// class values above this pick the long queue
	localparam logic [7:0] TOS_LONG_LIMIT = 8'd4;

	// operations
	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK            = 3'd0,
		ST_OVER_THR      = 3'd1,
		ST_OVERFLOW      = 3'd2,
		ST_NOT_MARKABLE  = 3'd3,
		ST_BAD_PORT      = 3'd4,
		ST_DEQ_UNDERFLOW = 3'd5
	} st_t;

	// configuration register indexes
	typedef enum logic [3:0] {
		REG_SHARED_MODE    = 4'd0,
		REG_THRESHOLD_MODE = 4'd1,
		REG_ALPHA_SHIFT    = 4'd2,
		REG_BUFFER_BYTES   = 4'd3,
		REG_ACTIVE_PORTS   = 4'd4,
		REG_PP_BUFFER      = 4'd5,
		REG_MARK_EN        = 4'd6,
		REG_ECN_THR_KIB    = 4'd7
	} reg_idx_t;

	// per-port memory word
	typedef struct packed {
		logic [DROP_W-1:0] drops;
		logic [QB_W-1:0]   qbytes;
	} entry_t;

	// configuration seen by the decision stage
	typedef struct packed {
		logic              shared;
		logic [QB_W-1:0]   buffer_bytes;
		logic [QB_W-2:0]   static_limit;
		logic              ecn_en;
		logic [QB_W-1:0]   ecn_thr_bytes;
	} adm_cfg_t;

	// one item at the decision stage
	typedef struct packed {
		op_t               op;
		logic              bad;
		logic [LEN_W-1:0]  len;
		logic              is_ipv4;
		logic [1:0]        ecn;
		logic [7:0]        tos;
		entry_t            entry;
		logic [THR_W-1:0]  thr;
		logic [OCC_W-1:0]  occ;
		logic [OCC_W:0]    occ_add;
		logic [OCC_W-1:0]  occ_sub;
	} adm_req_t;

	// decision and write-back values
	typedef struct packed {
		st_t               status;
		logic              mark;
		logic              longq;
		logic              we;
		entry_t            entry;
		logic [OCC_W-1:0]  occ;
	} adm_res_t;

endpackage

// File: rtl/core/oqad_mem.sv
// per-port state memory: queue bytes and drop counter, valid bits for reset
`timescale 1ns / 1ps
module oqad_mem #(
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [$clog2(DEPTH)-1:0]   rd_addr,
	output oqad_pkg::entry_t           rd_data,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  oqad_pkg::entry_t           wr_data
);
	import oqad_pkg::*;

	entry_t             mem [DEPTH];
	entry_t             rdata_q;
	logic [DEPTH-1:0]   vld_q;
	logic               rd_vld_q;

	// storage array, one write and one registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// entries read as zero until first written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rdata_q : '0;

endmodule

// File: rtl/core/oqad_div.sv
// restoring divider for the equal share, one quotient bit per cycle
`timescale 1ns / 1ps
module oqad_div #(
	parameter int NUM_PORTS = oqad_pkg::NUM_PORTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [oqad_pkg::SHARE_W-1:0]     dividend,
	input  logic [$clog2(NUM_PORTS+1)-1:0]   divisor,
	output logic                             busy,
	output logic [oqad_pkg::SHARE_W-1:0]     quotient
);
	import oqad_pkg::*;

	localparam int VW        = $clog2(NUM_PORTS + 1);
	localparam int CNTW      = $clog2(SHARE_W);
	localparam int RST_PORTS = (NUM_PORTS < ACTIVE_PORTS_RST) ? NUM_PORTS : ACTIVE_PORTS_RST;
	localparam int QUOT_RST  = BUFFER_BYTES_RST / RST_PORTS;

	logic                busy_q;
	logic [CNTW-1:0]     cnt_q;
	logic [SHARE_W-1:0]  dvd_q;
	logic [VW-1:0]       rem_q;
	logic [VW-1:0]       dsr_q;
	logic [SHARE_W-1:0]  quot_q;

	logic [VW:0]         trial;
	logic [VW:0]         diff;
	logic                ge;
	logic [VW-1:0]       rem_nxt;
	logic [SHARE_W-1:0]  dvd_nxt;

	// one trial subtraction per cycle
	always_comb begin
		trial   = {rem_q, dvd_q[SHARE_W-1]};
		ge      = trial >= {1'b0, dsr_q};
		diff    = trial - {1'b0, dsr_q};
		rem_nxt = ge ? diff[VW-1:0] : trial[VW-1:0];
		dvd_nxt = {dvd_q[SHARE_W-2:0], ge};
	end

	// iteration control and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			quot_q <= SHARE_W'(QUOT_RST);
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNTW'(SHARE_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				quot_q <= dvd_nxt;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= dvd_nxt;
			rem_q <= rem_nxt;
		end
	end

	assign busy     = busy_q;
	assign quotient = quot_q;

endmodule

// File: rtl/core/oqad_adm.sv
// admission decision: thresholds, ecn marking, drops and dequeue update
`timescale 1ns / 1ps
module oqad_adm (
	input  oqad_pkg::adm_req_t  req,
	input  oqad_pkg::adm_cfg_t  cfg,
	output oqad_pkg::adm_res_t  res
);
	import oqad_pkg::*;

	logic [QB_W:0]   qenq;
	logic            want_mark;
	st_t             st;

	always_comb begin
		qenq      = {1'b0, req.entry.qbytes} + {{(QB_W + 1 - LEN_W){1'b0}}, req.len};
		want_mark = cfg.ecn_en && (req.entry.qbytes >= cfg.ecn_thr_bytes);
		st        = ST_OK;
		res       = '0;
		res.entry = req.entry;
		res.occ   = req.occ;

		if (req.bad) begin
			// bad port: no state change, fields cleared
			res.status = ST_BAD_PORT;
			res.entry  = '0;
		end else if (req.op == OP_DEQ) begin
			// dequeue completion
			res.we = 1'b1;
			if ({{(QB_W - LEN_W){1'b0}}, req.len} > req.entry.qbytes) begin
				res.status = ST_DEQ_UNDERFLOW;
			end else begin
				res.status       = ST_OK;
				res.entry.qbytes = req.entry.qbytes - {{(QB_W - LEN_W){1'b0}}, req.len};
				res.occ          = req.occ_sub;
			end
		end else begin
			// enqueue admission
			res.we = 1'b1;
			if (cfg.shared) begin
				if ({{(THR_W - QB_W - 1){1'b0}}, qenq} > req.thr) begin
					st = ST_OVER_THR;
				end else if (req.occ_add > {{(OCC_W + 1 - QB_W){1'b0}}, cfg.buffer_bytes}) begin
					st = ST_OVERFLOW;
				end
			end else if (qenq > {2'b00, cfg.static_limit}) begin
				st = ST_OVERFLOW;
			end

			// ecn marking on admitted items
			if (st == ST_OK && want_mark) begin
				if (req.is_ipv4 && req.ecn != 2'b00) begin
					res.mark = 1'b1;
				end else begin
					st = ST_NOT_MARKABLE;
				end
			end

			res.status = st;
			if (st == ST_OK) begin
				res.longq        = req.tos > TOS_LONG_LIMIT;
				res.entry.qbytes = qenq[QB_W-1:0];
				res.occ          = (req.occ_add > {1'b0, OCC_MAX}) ? OCC_MAX
				                                                  : req.occ_add[OCC_W-1:0];
			end else begin
				res.mark = 1'b0;
				if (req.tos <= TOS_LONG_LIMIT) begin
					res.entry.drops = req.entry.drops + 1'b1;
				end
			end
		end
	end

endmodule

// File: rtl/core/output_queue_admission_dt_ecn.sv
// output queue admission with dynamic threshold and ecn marking, top level
//
// channel   direction  handshake                  payload
// item in   in         start & !busy              op, port, packet_length, is_ipv4,
//                                                 ecn_field, class_tos
// result    out        done, one cycle            status, ecn_mark, use_long_queue,
//                                                 queue_bytes_after, occupancy_after,
//                                                 drop_count
// config    in         cfg_valid & cfg_ready      cfg_index, cfg_data
//
// an item passes the registered state memory read with the threshold arithmetic, then
// the decision and write-back, then the result registers; the next item may start while
// the previous writes back, a same-port write is forwarded into the read stage. writing
// buffer_bytes or active_ports recomputes the equal share in a bit-serial divider, busy
// is held high and cfg_ready low until the divider is done. after reset the per-port
// state reads as zero, ready at once, no stalls out.
`timescale 1ns / 1ps
`include "output_queue_admission_dt_ecn_macros.svh"
module output_queue_admission_dt_ecn #(
	parameter int NUM_PORTS = oqad_pkg::NUM_PORTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  logic         op,
	input  logic [3:0]   port,
	input  logic [15:0]  packet_length,
	input  logic         is_ipv4,
	input  logic [1:0]   ecn_field,
	input  logic [7:0]   class_tos,
	output logic         done,
	output logic [2:0]   status,
	output logic         ecn_mark,
	output logic         use_long_queue,
	output logic [23:0]  queue_bytes_after,
	output logic [27:0]  occupancy_after,
	output logic [31:0]  drop_count,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [3:0]   cfg_index,
	input  logic [23:0]  cfg_data
);
	import oqad_pkg::*;

	localparam int AW = $clog2(NUM_PORTS);
	localparam int PW = $clog2(NUM_PORTS + 1);
	localparam int CW = (PW > 5) ? PW : 5;

	// configuration registers
	logic                shared_mode_q;
	logic                threshold_mode_q;
	logic [3:0]          alpha_shift_q;
	logic [QB_W-1:0]     buffer_bytes_q;
	logic [4:0]          active_ports_q;
	logic [QB_W-1:0]     pp_buffer_q;
	logic                mark_en_q;
	logic [13:0]         ecn_thr_kib_q;
	logic                share_pend_q;

	logic                cfg_wr;
	logic                div_busy;
	logic [SHARE_W-1:0]  equal_share;
	logic [CW-1:0]       ap_ext;
	logic [PW-1:0]       eff_ports;

	// item path
	logic                accept;
	logic                port_bad;
	logic [AW-1:0]       port_addr;

	logic                s1_valid_q;
	op_t                 op_s1;
	logic                bad_s1;
	logic [LEN_W-1:0]    len_s1;
	logic                ipv4_s1;
	logic [1:0]          ecn_s1;
	logic [7:0]          tos_s1;
	logic [AW-1:0]       addr_s1;
	logic                fwd_s1;
	entry_t              fwd_data_s1;

	logic                s2_valid_q;
	op_t                 op_s2;
	logic                bad_s2;
	logic [LEN_W-1:0]    len_s2;
	logic                ipv4_s2;
	logic [1:0]          ecn_s2;
	logic [7:0]          tos_s2;
	logic [AW-1:0]       addr_s2;
	entry_t              entry_s2;
	logic [THR_W-1:0]    thr_s2;
	logic [OCC_W:0]      occ_add_s2;
	logic [OCC_W-1:0]    occ_sub_s2;

	logic [OCC_W-1:0]    occ_q;
	entry_t              mem_rdata;
	entry_t              entry_cur;
	logic [QB_W-1:0]     free_bytes;
	logic [38:0]         free_shl;
	logic [THR_W-1:0]    thr_cur;
	logic [OCC_W:0]      occ_add_cur;
	logic [OCC_W-1:0]    occ_sub_cur;

	adm_req_t            req;
	adm_cfg_t            acfg;
	adm_res_t            res;
	logic                wb_en;

	// result registers
	logic                done_q;
	st_t                 status_q;
	logic                mark_q;
	logic                longq_q;
	logic [QB_W-1:0]     qbytes_q;
	logic [OCC_W-1:0]    occ_out_q;
	logic [DROP_W-1:0]   drops_q;

	// handshakes
	assign cfg_ready = !(share_pend_q || div_busy);
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign busy      = s1_valid_q || share_pend_q || div_busy;
	assign accept    = start && !busy;

	// configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shared_mode_q    <= 1'b1;
			threshold_mode_q <= 1'b1;
			alpha_shift_q    <= '0;
			buffer_bytes_q   <= QB_W'(BUFFER_BYTES_RST);
			active_ports_q   <= 5'(ACTIVE_PORTS_RST);
			pp_buffer_q      <= QB_W'(PP_BUFFER_RST);
			mark_en_q        <= 1'b0;
			ecn_thr_kib_q    <= 14'(ECN_THR_KIB_RST);
			share_pend_q     <= 1'b0;
		end else begin
			share_pend_q <= 1'b0;
			if (cfg_wr) begin
				unique case (reg_idx_t'(cfg_index))
					REG_SHARED_MODE:    shared_mode_q    <= cfg_data[0];
					REG_THRESHOLD_MODE: threshold_mode_q <= cfg_data[0];
					REG_ALPHA_SHIFT:    alpha_shift_q    <= cfg_data[3:0];
					REG_BUFFER_BYTES: begin
						buffer_bytes_q <= cfg_data;
						share_pend_q   <= 1'b1;
					end
					REG_ACTIVE_PORTS: begin
						active_ports_q <= cfg_data[4:0];
						share_pend_q   <= 1'b1;
					end
					REG_PP_BUFFER:      pp_buffer_q      <= cfg_data;
					REG_MARK_EN:        mark_en_q        <= cfg_data[0];
					REG_ECN_THR_KIB:    ecn_thr_kib_q    <= cfg_data[13:0];
					default: ;
				endcase
			end
		end
	end

	// ports in use, clamped to 1..NUM_PORTS
	always_comb begin
		ap_ext = CW'(active_ports_q);
		if (ap_ext == '0) begin
			eff_ports = PW'(1);
		end else if (ap_ext > CW'(NUM_PORTS)) begin
			eff_ports = PW'(NUM_PORTS);
		end else begin
			eff_ports = PW'(ap_ext);
		end
	end

	// equal share divider
	oqad_div #(
		.NUM_PORTS (NUM_PORTS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (share_pend_q),
		.dividend (buffer_bytes_q),
		.divisor  (eff_ports),
		.busy     (div_busy),
		.quotient (equal_share)
	);

	// port check and memory address at acceptance
	assign port_bad  = 32'(port) >= 32'(eff_ports);
	assign port_addr = AW'(port);

	// per-port state memory
	oqad_mem #(
		.DEPTH (NUM_PORTS)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (port_addr),
		.rd_data (mem_rdata),
		.we      (wb_en),
		.wr_addr (addr_s2),
		.wr_data (res.entry)
	);

	// stage 1 and stage 2 valid control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept;
			s2_valid_q <= s1_valid_q;
		end
	end

	// stage 1 payload, forward a same-port write-back
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= op_t'(op);
			bad_s1      <= port_bad;
			len_s1      <= packet_length;
			ipv4_s1     <= is_ipv4;
			ecn_s1      <= ecn_field;
			tos_s1      <= class_tos;
			addr_s1     <= port_addr;
			fwd_s1      <= wb_en && (addr_s2 == port_addr);
			fwd_data_s1 <= res.entry;
		end
	end

	// stage 1: threshold and occupancy arithmetic
	always_comb begin
		entry_cur  = fwd_s1 ? fwd_data_s1 : mem_rdata;
		free_bytes = ({{(OCC_W - QB_W){1'b0}}, buffer_bytes_q} > occ_q)
		             ? buffer_bytes_q - occ_q[QB_W-1:0] : '0;
		free_shl   = {15'b0, free_bytes} << alpha_shift_q;
		if (!threshold_mode_q) begin
			thr_cur = {{(THR_W - SHARE_W){1'b0}}, equal_share};
		end else if (free_shl[38:THR_W] != '0) begin
			thr_cur = {THR_W{1'b1}};
		end else begin
			thr_cur = free_shl[THR_W-1:0];
		end
		occ_add_cur = {1'b0, occ_q} + {{(OCC_W + 1 - LEN_W){1'b0}}, len_s1};
		occ_sub_cur = (occ_q >= {{(OCC_W - LEN_W){1'b0}}, len_s1})
		              ? occ_q - {{(OCC_W - LEN_W){1'b0}}, len_s1} : '0;
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (s1_valid_q) begin
			op_s2      <= op_s1;
			bad_s2     <= bad_s1;
			len_s2     <= len_s1;
			ipv4_s2    <= ipv4_s1;
			ecn_s2     <= ecn_s1;
			tos_s2     <= tos_s1;
			addr_s2    <= addr_s1;
			entry_s2   <= entry_cur;
			thr_s2     <= thr_cur;
			occ_add_s2 <= occ_add_cur;
			occ_sub_s2 <= occ_sub_cur;
		end
	end

	// stage 2: decision
	always_comb begin
		req.op       = op_s2;
		req.bad      = bad_s2;
		req.len      = len_s2;
		req.is_ipv4  = ipv4_s2;
		req.ecn      = ecn_s2;
		req.tos      = tos_s2;
		req.entry    = entry_s2;
		req.thr      = thr_s2;
		req.occ      = occ_q;
		req.occ_add  = occ_add_s2;
		req.occ_sub  = occ_sub_s2;

		acfg.shared        = shared_mode_q;
		acfg.buffer_bytes  = buffer_bytes_q;
		acfg.static_limit  = pp_buffer_q[QB_W-1:1];
		acfg.ecn_en        = mark_en_q;
		acfg.ecn_thr_bytes = {ecn_thr_kib_q, 10'b0};
	end

	oqad_adm u_adm (
		.req (req),
		.cfg (acfg),
		.res (res)
	);

	assign wb_en = s2_valid_q && res.we;

	// running total occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (s2_valid_q) begin
			occ_q <= res.occ;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= s2_valid_q;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (s2_valid_q) begin
			status_q  <= res.status;
			mark_q    <= res.mark;
			longq_q   <= res.longq;
			qbytes_q  <= res.entry.qbytes;
			occ_out_q <= res.occ;
			drops_q   <= res.entry.drops;
		end
	end

	assign done              = done_q;
	assign status            = status_q;
	assign ecn_mark          = mark_q;
	assign use_long_queue    = longq_q;
	assign queue_bytes_after = qbytes_q;
	assign occupancy_after   = occ_out_q;
	assign drop_count        = drops_q;

	// checks
	`OQAD_ASSERT_NEXT(a_accept_fills_s1, accept, s1_valid_q, "accepted item did not reach stage 1")
	`OQAD_ASSERT_NEXT(a_s2_gives_result, s2_valid_q, done, "decision stage gave no result")
	`OQAD_ASSERT_SAME(a_mark_only_ok, done && ecn_mark, status == ST_OK, "mark on refused item")
	`OQAD_ASSERT_SAME(a_long_only_ok, done && use_long_queue, status == ST_OK, "long queue on refused item")
	`OQAD_ASSERT_SAME(a_share_blocks, share_pend_q || div_busy, busy && !cfg_ready, "item or write during share update")

endmodule

// File: dv/tb_output_queue_admission_dt_ecn.sv
// testbench for the output queue admission block: predicted verdicts checked field by field
`timescale 1ns / 1ps
module tb_output_queue_admission_dt_ecn;
	import oqad_pkg::*;

	localparam int NP = NUM_PORTS_DEF;

	// one packet event as offered to the block
	typedef struct {
		op_t         op;
		logic [3:0]  port;
		logic [15:0] length;
		logic        is_ipv4;
		logic [1:0]  ecn;
		logic [7:0]  tos;
	} admission_item_t;

	// one admission verdict as reported by the block
	typedef struct {
		st_t         status;
		logic        mark;
		logic        longq;
		logic [23:0] qbytes;
		logic [27:0] occ;
		logic [31:0] drops;
	} admission_result_t;

	// tracks queue state and settings, predicts verdicts and checks them in order
	class admission_scoreboard;
		logic        shared_mode;
		logic        threshold_mode;
		logic [3:0]  alpha_shift;
		logic [23:0] buffer_bytes;
		logic [4:0]  active_ports;
		logic [23:0] per_port_buffer;
		logic        mark_en;
		logic [13:0] ecn_thr_kib;
		logic [23:0] queue_bytes [NP];
		logic [31:0] drops [NP];
		logic [27:0] occupancy;
		logic [23:0] equal_share;
		admission_result_t pending_verdicts [$];
		int unsigned fail_count;
		int unsigned mark_count;
		int unsigned status_seen [6];

		function new();
			shared_mode = 1'b1;
			threshold_mode = 1'b1;
			alpha_shift = '0;
			buffer_bytes = 24'(BUFFER_BYTES_RST);
			active_ports = 5'(ACTIVE_PORTS_RST);
			per_port_buffer = 24'(PP_BUFFER_RST);
			mark_en = 1'b0;
			ecn_thr_kib = 14'(ECN_THR_KIB_RST);
			foreach (queue_bytes[i]) begin
				queue_bytes[i] = '0;
				drops[i] = '0;
			end
			occupancy = '0;
			equal_share = 24'(buffer_bytes / port_limit());
			fail_count = 0;
			mark_count = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		// active ports clamped to the implemented range
		function int unsigned port_limit();
			if (active_ports == 0) return 1;
			if (active_ports > NP) return NP;
			return active_ports;
		endfunction

		function void write_reg(logic [3:0] idx, logic [23:0] data);
			case (idx)
				REG_SHARED_MODE:    shared_mode = data[0];
				REG_THRESHOLD_MODE: threshold_mode = data[0];
				REG_ALPHA_SHIFT:    alpha_shift = data[3:0];
				REG_BUFFER_BYTES: begin
					buffer_bytes = data;
					equal_share = 24'(buffer_bytes / port_limit());
				end
				REG_ACTIVE_PORTS: begin
					active_ports = data[4:0];
					equal_share = 24'(buffer_bytes / port_limit());
				end
				REG_PP_BUFFER:      per_port_buffer = data;
				REG_MARK_EN:        mark_en = data[0];
				REG_ECN_THR_KIB:    ecn_thr_kib = data[13:0];
				default: ;
			endcase
		endfunction

		// decide admission for an accepted item, update state, queue the verdict
		function void admit_item(admission_item_t it);
			admission_result_t r;
			logic [31:0] qlen;
			logic [31:0] qenq;
			logic [31:0] thr;
			logic [63:0] free_b;
			logic [63:0] shifted;
			logic [63:0] occ_sum;
			logic        want_mark;
			int unsigned p;
			p = it.port;
			r.status = ST_OK;
			r.mark = 1'b0;
			r.longq = 1'b0;
			if (p >= port_limit()) begin
				r.status = ST_BAD_PORT;
				r.qbytes = '0;
				r.occ = occupancy;
				r.drops = '0;
			end else begin
				if (it.op == OP_DEQ) begin
					if (32'(it.length) > 32'(queue_bytes[p])) begin
						r.status = ST_DEQ_UNDERFLOW;
					end else begin
						queue_bytes[p] = queue_bytes[p] - 24'(it.length);
						occupancy = (occupancy >= 28'(it.length)) ?
							occupancy - 28'(it.length) : '0;
					end
				end else begin
					qlen = 32'(queue_bytes[p]);
					qenq = qlen + 32'(it.length);
					occ_sum = 64'(occupancy) + 64'(it.length);
					want_mark = mark_en && (qlen >= (32'(ecn_thr_kib) << 10));
					// shared buffer: per-queue threshold first, then whole buffer
					if (shared_mode) begin
						if (!threshold_mode) begin
							thr = 32'(equal_share);
						end else begin
							free_b = (buffer_bytes > occupancy) ?
								64'(buffer_bytes) - 64'(occupancy) : 64'd0;
							shifted = free_b << alpha_shift;
							thr = (shifted > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : shifted[31:0];
						end
						if (qenq > thr) r.status = ST_OVER_THR;
						else if (occ_sum > 64'(buffer_bytes)) r.status = ST_OVERFLOW;
					end else if (qenq > 32'(per_port_buffer >> 1)) begin
						r.status = ST_OVERFLOW;
					end
					// congestion marking only for admitted packets
					if (r.status == ST_OK && want_mark) begin
						if (it.is_ipv4 && it.ecn != 2'd0) r.mark = 1'b1;
						else r.status = ST_NOT_MARKABLE;
					end
					if (r.status == ST_OK) begin
						r.longq = (it.tos > TOS_LONG_LIMIT);
						queue_bytes[p] = qenq[23:0];
						occupancy = (occ_sum > 64'(OCC_MAX)) ? OCC_MAX : occ_sum[27:0];
					end else begin
						r.mark = 1'b0;
						if (it.tos <= TOS_LONG_LIMIT) drops[p] = drops[p] + 32'd1;
					end
				end
				r.qbytes = queue_bytes[p];
				r.occ = occupancy;
				r.drops = drops[p];
			end
			status_seen[int'(r.status)]++;
			mark_count += r.mark;
			pending_verdicts.push_back(r);
		endfunction

		function void check_verdict(admission_result_t got);
			admission_result_t exp;
			if (pending_verdicts.size() == 0) begin
				$error("verdict with no item outstanding: status %0d", got.status);
				fail_count++;
				return;
			end
			exp = pending_verdicts.pop_front();
			if (got.status !== exp.status) begin
				$error("status: expected %0d, got %0d", exp.status, got.status);
				fail_count++;
			end
			if (got.mark !== exp.mark) begin
				$error("ecn_mark: expected %0d, got %0d", exp.mark, got.mark);
				fail_count++;
			end
			if (got.longq !== exp.longq) begin
				$error("use_long_queue: expected %0d, got %0d", exp.longq, got.longq);
				fail_count++;
			end
			if (got.qbytes !== exp.qbytes) begin
				$error("queue_bytes_after: expected %0d, got %0d", exp.qbytes, got.qbytes);
				fail_count++;
			end
			if (got.occ !== exp.occ) begin
				$error("occupancy_after: expected %0d, got %0d", exp.occ, got.occ);
				fail_count++;
			end
			if (got.drops !== exp.drops) begin
				$error("drop_count: expected %0d, got %0d", exp.drops, got.drops);
				fail_count++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        op = 1'b0;
	logic [3:0]  port = '0;
	logic [15:0] packet_length = '0;
	logic        is_ipv4 = 1'b0;
	logic [1:0]  ecn_field = '0;
	logic [7:0]  class_tos = '0;
	logic        done;
	logic [2:0]  status;
	logic        ecn_mark;
	logic        use_long_queue;
	logic [23:0] queue_bytes_after;
	logic [27:0] occupancy_after;
	logic [31:0] drop_count;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_index = '0;
	logic [23:0] cfg_data = '0;

	admission_scoreboard sb;
	int unsigned item_count = 0;
	int unsigned write_count = 0;

	output_queue_admission_dt_ecn u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.op                (op),
		.port              (port),
		.packet_length     (packet_length),
		.is_ipv4           (is_ipv4),
		.ecn_field         (ecn_field),
		.class_tos         (class_tos),
		.done              (done),
		.status            (status),
		.ecn_mark          (ecn_mark),
		.use_long_queue    (use_long_queue),
		.queue_bytes_after (queue_bytes_after),
		.occupancy_after   (occupancy_after),
		.drop_count        (drop_count),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	// 2 ns clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// verdict monitor, the block cannot be stalled
	always @(posedge clk) begin
		admission_result_t got;
		if (arst_n && done === 1'b1) begin
			got.status = st_t'(status);
			got.mark = ecn_mark;
			got.longq = use_long_queue;
			got.qbytes = queue_bytes_after;
			got.occ = occupancy_after;
			got.drops = drop_count;
			sb.check_verdict(got);
		end
	end

	// offer one item after a gap, return at the edge that accepts it
	task automatic send_item(input admission_item_t it, input int unsigned gap);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		op <= it.op;
		port <= it.port;
		packet_length <= it.length;
		is_ipv4 <= it.is_ipv4;
		ecn_field <= it.ecn;
		class_tos <= it.tos;
		do @(posedge clk); while (busy !== 1'b0);
		sb.admit_item(it);
		item_count++;
	endtask

	// one register write, junk above the register width for narrow fields
	task automatic write_reg(input logic [3:0] idx, input logic [23:0] value);
		logic [23:0] data;
		int unsigned w;
		case (idx)
			REG_SHARED_MODE, REG_THRESHOLD_MODE, REG_MARK_EN: w = 1;
			REG_ALPHA_SHIFT:  w = 4;
			REG_ACTIVE_PORTS: w = 5;
			REG_ECN_THR_KIB:  w = 14;
			default:          w = 24;
		endcase
		data = value;
		if (w < 24 && $urandom_range(0, 1) == 1) data = value | (24'($urandom()) << w);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.write_reg(idx, data);
		write_count++;
	endtask

	// stop offering items and let every verdict come back
	task automatic quiesce();
		start <= 1'b0;
		while (sb.pending_verdicts.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// random traffic: enqueues, dequeues that fit the queue, and underflowing dequeues
	task automatic run_traffic(input int unsigned n);
		admission_item_t it;
		int unsigned lim;
		int unsigned q;
		int unsigned pick;
		int unsigned gap;
		bit burst;
		burst = 1'b0;
		for (int unsigned i = 0; i < n; i++) begin
			if (i % 40 == 0) burst = ($urandom_range(0, 3) == 0);
			gap = burst ? 0 : $urandom_range(0, 9);
			lim = sb.port_limit();
			it.port = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) :
				4'($urandom_range(0, lim - 1));
			it.is_ipv4 = ($urandom_range(0, 3) != 0);
			it.ecn = 2'($urandom_range(0, 3));
			it.tos = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 8)) :
				8'($urandom_range(0, 255));
			q = sb.queue_bytes[it.port];
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				it.op = OP_DEQ;
				it.length = 16'($urandom_range(0, (q > 65535) ? 65535 : q));
			end else if (pick < 45) begin
				it.op = OP_DEQ;
				it.length = (q < 65535) ? 16'($urandom_range(q + 1, 65535)) :
					16'($urandom_range(0, 65535));
			end else begin
				it.op = OP_ENQ;
				case ($urandom_range(0, 3))
					0:       it.length = 16'($urandom_range(0, 1500));
					3:       it.length = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0;
					default: it.length = 16'($urandom_range(0, 65535));
				endcase
			end
			send_item(it, gap);
		end
	endtask

	// stimulus
	initial begin
		logic        sh;
		logic        tm;
		logic [3:0]  al;
		logic [23:0] buf_b;
		logic [4:0]  act;
		logic [23:0] ppb;
		logic        ecn_en;
		logic [13:0] kib;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default settings: plain admission, class split, dequeues incl. underflow
		send_item('{OP_ENQ, 4'd0, 16'd0, 1'b0, 2'd0, 8'd0}, 0);
		send_item('{OP_ENQ, 4'd15, 16'hFFFF, 1'b1, 2'd3, 8'd255}, 0);
		send_item('{OP_ENQ, 4'd1, 16'd1500, 1'b0, 2'd1, 8'd4}, 1);
		send_item('{OP_ENQ, 4'd1, 16'd1500, 1'b1, 2'd2, 8'd5}, 0);
		send_item('{OP_DEQ, 4'd1, 16'd3001, 1'b0, 2'd0, 8'd0}, 2);
		send_item('{OP_DEQ, 4'd1, 16'd3000, 1'b0, 2'd0, 8'd0}, 0);
		send_item('{OP_DEQ, 4'd15, 16'hFFFF, 1'b0, 2'd0, 8'd0}, 0);
		send_item('{OP_DEQ, 4'd2, 16'd0, 1'b0, 2'd0, 8'd0}, 0);

		// marking everywhere, small buffer: unmarkable drops, marks, threshold refusal
		quiesce();
		write_reg(REG_MARK_EN, 24'd1);
		write_reg(REG_ECN_THR_KIB, 24'd0);
		write_reg(REG_BUFFER_BYTES, 24'd100000);
		cfg_valid <= 1'b0;
		send_item('{OP_ENQ, 4'd3, 16'd100, 1'b0, 2'd3, 8'd0}, 0);
		send_item('{OP_ENQ, 4'd3, 16'd100, 1'b1, 2'd0, 8'd7}, 0);
		send_item('{OP_ENQ, 4'd3, 16'd100, 1'b1, 2'd1, 8'd0}, 0);
		send_item('{OP_ENQ, 4'd4, 16'hFFFF, 1'b1, 2'd2, 8'd0}, 0);
		send_item('{OP_ENQ, 4'd5, 16'd40000, 1'b1, 2'd3, 8'd0}, 0);

		// equal share threshold
		quiesce();
		write_reg(REG_THRESHOLD_MODE, 24'd0);
		cfg_valid <= 1'b0;
		send_item('{OP_ENQ, 4'd6, 16'd6250, 1'b1, 2'd2, 8'd1}, 0);
		send_item('{OP_ENQ, 4'd6, 16'd1, 1'b1, 2'd2, 8'd1}, 0);

		// wide dynamic threshold so the whole-buffer check refuses
		quiesce();
		write_reg(REG_THRESHOLD_MODE, 24'd1);
		write_reg(REG_ALPHA_SHIFT, 24'd2);
		cfg_valid <= 1'b0;
		send_item('{OP_ENQ, 4'd7, 16'd30000, 1'b1, 2'd3, 8'd2}, 0);

		// static half per-port limit
		quiesce();
		write_reg(REG_SHARED_MODE, 24'd0);
		write_reg(REG_PP_BUFFER, 24'd20000);
		cfg_valid <= 1'b0;
		send_item('{OP_ENQ, 4'd8, 16'd10000, 1'b1, 2'd3, 8'd3}, 0);
		send_item('{OP_ENQ, 4'd8, 16'd1, 1'b1, 2'd3, 8'd3}, 0);

		// ports beyond the active count
		quiesce();
		write_reg(REG_ACTIVE_PORTS, 24'd2);
		cfg_valid <= 1'b0;
		send_item('{OP_ENQ, 4'd9, 16'd64, 1'b1, 2'd1, 8'd0}, 0);
		send_item('{OP_DEQ, 4'd15, 16'd64, 1'b0, 2'd0, 8'd0}, 0);

		// random phases over a spread of settings, extremes included
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: {sh, tm, al, buf_b, act, ppb, ecn_en, kib} =
					{1'b1, 1'b1, 4'd0, 24'd300000, 5'd16, 24'd131072, 1'b1, 14'd20};
				1: {sh, tm, al, buf_b, act, ppb, ecn_en, kib} =
					{1'b1, 1'b0, 4'd2, 24'd400000, 5'd5, 24'd131072, 1'b1, 14'd8};
				2: {sh, tm, al, buf_b, act, ppb, ecn_en, kib} =
					{1'b1, 1'b1, 4'd15, 24'hFFFFFF, 5'd31, 24'hFFFFFF, 1'b0, 14'd16383};
				3: {sh, tm, al, buf_b, act, ppb, ecn_en, kib} =
					{1'b0, 1'b1, 4'd0, 24'd500000, 5'd16, 24'd200000, 1'b1, 14'd0};
				4: {sh, tm, al, buf_b, act, ppb, ecn_en, kib} =
					{1'b0, 1'b0, 4'd5, 24'd500000, 5'd0, 24'd0, 1'b1, 14'd3};
				5: {sh, tm, al, buf_b, act, ppb, ecn_en, kib} =
					{1'b1, 1'b1, 4'd3, 24'd0, 5'd12, 24'd60000, 1'b1, 14'd1};
				6: {sh, tm, al, buf_b, act, ppb, ecn_en, kib} =
					{1'b1, 1'b0, 4'd10, 24'hFFFFFF, 5'd1, 24'hFFFFFF, 1'b1, 14'd16383};
				default: {sh, tm, al, buf_b, act, ppb, ecn_en, kib} =
					{1'b1, 1'b1, 4'd1, 24'd1000000, 5'd16, 24'd131072, 1'b1, 14'd30};
			endcase
			quiesce();
			write_reg(REG_SHARED_MODE, 24'(sh));
			write_reg(REG_THRESHOLD_MODE, 24'(tm));
			write_reg(REG_ALPHA_SHIFT, 24'(al));
			write_reg(REG_BUFFER_BYTES, buf_b);
			write_reg(REG_ACTIVE_PORTS, 24'(act));
			write_reg(REG_PP_BUFFER, ppb);
			write_reg(REG_MARK_EN, 24'(ecn_en));
			write_reg(REG_ECN_THR_KIB, 24'(kib));
			// index past the register list must leave everything alone
			if (ph == 7) write_reg(4'($urandom_range(8, 15)), 24'($urandom()));
			cfg_valid <= 1'b0;
			run_traffic(240);
		end

		// drain and finish
		quiesce();
		repeat (10) @(posedge clk);
		$display("covered %0d items and %0d register writes over 8 random settings",
			item_count, write_count);
		$display("verdicts ok %0d over-thr %0d overflow %0d unmarkable %0d bad-port %0d %s %0d",
			sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
			sb.status_seen[4], "underflow", sb.status_seen[5]);
		if (sb.fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
